/* rtl/core/rpdr_pkg.sv */
// Shared types, codes and sizes for the ring probe direction router.
package rpdr_pkg;

  // Packet type codes
  localparam logic [1:0] PKT_DATA     = 2'd0;
  localparam logic [1:0] PKT_PROBE    = 2'd1;
  localparam logic [1:0] PKT_FEEDBACK = 2'd2;
  localparam logic [1:0] PKT_SPARE    = 2'd3;

  // Output port codes
  localparam logic [1:0] PORT_CW    = 2'd0;
  localparam logic [1:0] PORT_CCW   = 2'd1;
  localparam logic [1:0] PORT_LOCAL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_NODE_INDEX      = 2'd0;
  localparam logic [1:0] REG_RETEST_INTERVAL = 2'd1;
  localparam logic [1:0] REG_PROBE_LENGTH    = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int NODE_W     = 8;
  localparam int INTERVAL_W = 10;
  localparam int LEN_W      = 16;
  localparam int HOPS_W     = 16;
  localparam int COUNTER_W  = 11;

  localparam logic [NODE_W-1:0]     NODE_RST     = '0;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd30;
  localparam logic [LEN_W-1:0]      PROBE_LEN_RST = '0;

  // Per-origin probe flags, one per source address
  localparam int SEEN_DEPTH = 1 << NODE_W;

  // Default depth of the result queue
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]        packet_type;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] dest_node;
    logic              arrival_port;
    logic [LEN_W-1:0]  byte_length;
    logic [HOPS_W-1:0] hop_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        out_port;
    logic [1:0]        out_type;
    logic [NODE_W-1:0] out_source;
    logic [NODE_W-1:0] out_dest;
    logic [LEN_W-1:0]  out_length;
    logic [HOPS_W-1:0] out_hops;
    logic              last;
  } out_item_t;

  // One queued packet decision: the final result, optionally led by a probe pair
  typedef struct packed {
    logic      probes;
    out_item_t res;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

endpackage

/* rtl/core/rpdr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module rpdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rpdr_outq.sv */
// Result queue: holds packet decisions and plays each out as one to three beats.
module rpdr_outq #(
  parameter int DEPTH = rpdr_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rpdr_pkg::q_push_t            push,
  input  logic                         inflight,
  output logic                         credit_ok,
  input  logic [rpdr_pkg::LEN_W-1:0]   probe_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rpdr_pkg::out_item_t          out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  rpdr_pkg::q_entry_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [1:0]    phase;

  rpdr_pkg::q_entry_t head;
  logic pop;
  logic beat;
  logic [CW:0] committed;

  assign head      = entries[rd_ptr];
  assign out_valid = (count != '0);
  assign beat      = out_valid && !out_stall;

  // Room for the item in the processing stage plus one more
  assign committed = {1'b0, count} + (CW+1)'(inflight);
  assign credit_ok = (committed < (CW+1)'(DEPTH));

  always_comb begin
    out_item      = head.res;
    out_item.last = 1'b1;
    if (head.probes && (phase != 2'd2)) begin
      out_item.out_port   = (phase == 2'd0) ? rpdr_pkg::PORT_CW : rpdr_pkg::PORT_CCW;
      out_item.out_type   = rpdr_pkg::PKT_PROBE;
      out_item.out_length = probe_length;
      out_item.out_hops   = '0;
      out_item.last       = 1'b0;
    end
  end

  assign pop = beat && out_item.last;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      phase  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
        phase  <= '0;
      end else if (beat) begin
        phase <= phase + 2'd1;
      end
      count <= count + CW'(push.valid) - CW'(pop);
    end
  end

endmodule

/* rtl/core/ring_probe_direction_router_core.sv */
// Top level of the ring probe direction router.
//
// Takes one arriving packet per beat on in_item and emits the packets it forwards
// or creates on out_item, with last marking the final beat for each packet.
// Transit traffic, local delivery and probe answers give one result each and run
// at one packet per cycle while the input is not stalled; a local data packet that
// starts a probe round gives a probe clockwise, a probe counterclockwise and then
// the data, one after another on the single output port. Probe and feedback packets
// addressed here may give no result. The per-origin probe flags live in a
// 256 x 1 synchronous RAM; a packet's flag is read as it is accepted and
// written back in the next cycle, with the write forwarded to a following probe
// from the same origin. After reset the flag RAM is cleared, one entry a cycle,
// so no packet is taken until the pass is done; configuration writes are taken
// throughout. After every configuration write the input stalls while the start
// offset of the probe counter settles. cfg_ready is always high.
module ring_probe_direction_router_core #(
  parameter int QUEUE_DEPTH = rpdr_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // packet input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rpdr_pkg::in_item_t                in_item,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output rpdr_pkg::out_item_t               out_item,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpdr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rpdr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int NW  = rpdr_pkg::NODE_W;
  localparam int IW  = rpdr_pkg::INTERVAL_W;
  localparam int CNW = rpdr_pkg::COUNTER_W;
  localparam int AW  = $clog2(rpdr_pkg::SEEN_DEPTH);

  // floor(x/10) as (x*RECIP)>>SHIFT, exact over the ranges used here
  localparam int NODE_RECIP  = 205;
  localparam int NODE_SHIFT  = 11;
  localparam int PROD_RECIP  = 6554;
  localparam int PROD_SHIFT  = 16;
  localparam int PROD_W      = 4 + IW;
  localparam logic [1:0] HOLD_CYCLES = 2'd3;
  localparam logic [CNW-1:0] COUNTER_MAX = '1;

  // ---- configuration registers ----
  logic [NW-1:0]              node_index;
  logic [IW-1:0]              retest_interval;
  logic [rpdr_pkg::LEN_W-1:0] probe_length;
  logic                       cfg_we;
  logic [1:0]                 hold;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_index      <= rpdr_pkg::NODE_RST;
      retest_interval <= rpdr_pkg::INTERVAL_RST;
      probe_length    <= rpdr_pkg::PROBE_LEN_RST;
      hold            <= HOLD_CYCLES;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rpdr_pkg::REG_NODE_INDEX:      node_index      <= cfg_data[NW-1:0];
          rpdr_pkg::REG_RETEST_INTERVAL: retest_interval <= cfg_data[IW-1:0];
          rpdr_pkg::REG_PROBE_LENGTH:    probe_length    <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_we) begin
        hold <= HOLD_CYCLES;
      end else if (hold != '0) begin
        hold <= hold - 2'd1;
      end
    end
  end

  // ---- start offset: floor((node % 10) * interval / 10), one multiply per stage ----
  logic [NW+8-1:0]   node_scaled;
  logic [3:0]        node_rem;
  logic [PROD_W-1:0] offset_prod;
  logic [PROD_W+13-1:0] prod_scaled;
  logic [CNW-1:0]    start_offset;
  logic [4:0]        node_tens;

  assign node_scaled = {8'd0, node_index} * (NW+8)'(NODE_RECIP);
  assign node_tens   = 5'(node_scaled >> NODE_SHIFT);
  assign prod_scaled = {13'd0, offset_prod} * (PROD_W+13)'(PROD_RECIP);

  always_ff @(posedge clk) begin
    node_rem     <= 4'(node_index - NW'({node_tens, 3'd0} + {2'd0, node_tens, 1'b0}));
    offset_prod  <= PROD_W'(node_rem) * PROD_W'(retest_interval);
    start_offset <= CNW'(prod_scaled >> PROD_SHIFT);
  end

  // ---- flag RAM clearing pass after reset ----
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---- input acceptance and processing stage ----
  logic               credit_ok;
  logic               accept;
  logic               s1_valid;
  rpdr_pkg::in_item_t s1;

  assign in_stall = clearing || (hold != '0) || !credit_ok;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
  end

  // flag RAM: read on accept, written back from the processing stage
  logic          seen_rdata;
  logic          seen_we;
  logic          seen_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;

  assign ram_we    = clearing || seen_we;
  assign ram_waddr = clearing ? clr_addr : s1.source_node;
  assign ram_wdata = clearing ? 1'b0 : seen_wdata;

  rpdr_ram #(
    .WIDTH (1),
    .DEPTH (rpdr_pkg::SEEN_DEPTH)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_item.source_node),
    .rdata (seen_rdata)
  );

  // write made in the same cycle as this item's read: the RAM returned old data
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic          fwd_data;
  logic          seen_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= seen_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1.source_node;
    fwd_data <= seen_wdata;
  end

  assign seen_flag = (fwd_valid && (fwd_addr == s1.source_node)) ? fwd_data : seen_rdata;

  // ---- routing state ----
  logic [CNW-1:0] sent_counter;
  logic           retest_due;
  logic           first_pending;
  logic           preferred_port;

  logic [CNW-1:0] sent_counter_next;
  logic           retest_due_next;
  logic           first_pending_next;
  logic           preferred_port_next;

  logic [CNW-1:0] cnt_base;
  logic [CNW-1:0] cnt_round;
  logic [CNW-1:0] cnt_inc;
  logic           here;
  logic           opp;
  logic [rpdr_pkg::HOPS_W-1:0] hops_inc;
  rpdr_pkg::q_push_t push;

  assign here     = (s1.dest_node == node_index);
  assign opp      = !s1.arrival_port;
  assign hops_inc = (s1.hop_count == '1) ? s1.hop_count : s1.hop_count + 1'b1;

  // local data counter path: start offset, round restart, saturating count
  assign cnt_base  = first_pending ? start_offset : sent_counter;
  assign cnt_round = retest_due ? '0 : cnt_base;
  assign cnt_inc   = (cnt_round == COUNTER_MAX) ? cnt_round : cnt_round + 1'b1;

  always_comb begin
    sent_counter_next   = sent_counter;
    retest_due_next     = retest_due;
    first_pending_next  = first_pending;
    preferred_port_next = preferred_port;
    seen_we             = 1'b0;
    seen_wdata          = !seen_flag;

    push.valid                  = 1'b0;
    push.entry.probes           = 1'b0;
    push.entry.res.out_port     = {1'b0, opp};
    push.entry.res.out_type     = s1.packet_type;
    push.entry.res.out_source   = s1.source_node;
    push.entry.res.out_dest     = s1.dest_node;
    push.entry.res.out_length   = s1.byte_length;
    push.entry.res.out_hops     = s1.hop_count;
    push.entry.res.last         = 1'b1;

    if (s1_valid) begin
      case (s1.packet_type)
        rpdr_pkg::PKT_FEEDBACK: begin
          if (here) begin
            preferred_port_next = s1.arrival_port;
          end else begin
            push.valid = 1'b1;
          end
        end
        rpdr_pkg::PKT_PROBE: begin
          if (!here) begin
            push.valid = 1'b1;
          end else begin
            seen_we = 1'b1;
            if (!seen_flag) begin
              // answer with feedback back the way the probe came
              push.valid                = 1'b1;
              push.entry.res.out_port   = {1'b0, s1.arrival_port};
              push.entry.res.out_type   = rpdr_pkg::PKT_FEEDBACK;
              push.entry.res.out_source = s1.dest_node;
              push.entry.res.out_dest   = s1.source_node;
              push.entry.res.out_hops   = '0;
            end
          end
        end
        default: begin
          // data, and the unused type code handled as data
          push.valid = 1'b1;
          if (here) begin
            push.entry.res.out_port = rpdr_pkg::PORT_LOCAL;
          end else if (s1.source_node == node_index) begin
            push.entry.probes       = first_pending || retest_due;
            push.entry.res.out_port = {1'b0, preferred_port};
            push.entry.res.out_hops = hops_inc;
            first_pending_next      = 1'b0;
            sent_counter_next       = cnt_inc;
            retest_due_next         = (cnt_inc > CNW'(retest_interval));
          end else begin
            push.entry.res.out_hops = hops_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_counter   <= '0;
      retest_due     <= 1'b0;
      first_pending  <= 1'b1;
      preferred_port <= 1'b0;
    end else begin
      sent_counter   <= sent_counter_next;
      retest_due     <= retest_due_next;
      first_pending  <= first_pending_next;
      preferred_port <= preferred_port_next;
    end
  end

  // ---- result queue and beat sequencing ----
  rpdr_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .inflight     (s1_valid),
    .credit_ok    (credit_ok),
    .probe_length (probe_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

  // ---- checks ----
  // only probe beats lead a packet's final beat
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last) |-> (out_item.out_type == rpdr_pkg::PKT_PROBE))
    else $error("non-final beat is not a probe");

  // a probe round is not split: the next beat is already waiting
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_item.last) |=> out_valid)
    else $error("probe round broken up");

  // the first round happens once
  assert property (@(posedge clk) disable iff (rst)
    !first_pending |=> !first_pending)
    else $error("first probe round re-armed");

  // flag RAM is never written from two sources at once
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("packet processed during flag clearing");

endmodule
